FILE: sv/aenc_pkg.sv
// Shared constants, types and a helper function of the arithmetic encoder.
`default_nettype none
package aenc_pkg;

	// Interval registers and model counts
	localparam int DATA_W = 16;
	localparam int CNT_W  = 14;

	// Divider: 30-bit dividend, two quotient bits per cycle
	localparam int DIV_W      = 30;
	localparam int DIV_STEPS  = DIV_W / 2;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	// Pending underflow bound, never above 41 so one item yields at most eight bytes
	localparam int MAX_PENDING_UNDERFLOW = 32;
	localparam int PENDING_CAP = (MAX_PENDING_UNDERFLOW < 41) ? MAX_PENDING_UNDERFLOW : 41;
	localparam int PEND_W = 6;

	localparam logic [DATA_W-1:0] INITIAL_RANGE = 16'hFFFF;
	localparam logic [DATA_W-1:0] THRESH_RESET  = 16'h4000;
	localparam logic [DATA_W-1:0] TOP_BIT       = 16'h8000;
	localparam logic [DATA_W-1:0] LOW_MASK      = 16'h7FFF;
	localparam logic [7:0]        BYTE_MSB      = 8'h80;
	localparam logic              MARK_BIT      = 1'b1;

	// Byte buffer of one item
	localparam int BUF_DEPTH = 8;
	localparam int BUF_IDX_W = 3;
	localparam int BUF_CNT_W = 4;

	// Commands
	localparam logic [1:0] CMD_ENCODE = 2'd0;
	localparam logic [1:0] CMD_INIT   = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	// Control from the sequencer to the output buffer
	typedef struct packed {
		logic       push;
		logic [7:0] push_byte;
		logic       drain;
		logic       sat;
	} aenc_obuf_ctl_t;

	// Count leading zeros of a 16-bit word (16 for zero)
	function automatic logic [4:0] lzc16(input logic [DATA_W-1:0] v);
		logic [4:0] n;
		n = 5'd16;
		for (int i = 0; i < DATA_W; i++) begin
			if (v[i]) n = 5'(DATA_W - 1 - i);
		end
		return n;
	endfunction

endpackage
`default_nettype wire

FILE: sv/arithmetic_encoder_16bit.sv
// Top level of the 16-bit arithmetic encoder: sequencer, interval registers and bit packer.
`default_nettype none
// Encodes one command word at a time. An encode word narrows the 16-bit low and range
// registers with two divisions by total_count on one shared divider that retires two
// quotient bits per cycle (15 steps a pass), then shifts out settled bits one per cycle,
// the leading bit first and pending underflow bits after it, packing them MSB first into
// bytes. An output word that waits on m_tready holds the encoder in its drain step.
// s_tready is high only between words. Each word yields one output word per completed
// byte, or a single empty word (tuser low) when it completes none; tlast marks the final
// output word of each input word. The underflow threshold is written through
// cfg_valid/cfg_data; the user must write it only while idle, as the block does not
// enforce this.
module arithmetic_encoder_16bit import aenc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [13:0] sym_base, [27:14] sym_freq, [41:28] total_count
	input  logic [1:0]  s_tuser,   // [1:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] code_byte, [8] underflow_saturated
	output logic        m_tuser,   // [0] byte_valid
	output logic        m_tlast,   // last_of_item
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // underflow_threshold
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MUL1   = 4'd1;
	localparam logic [3:0] S_DIV1   = 4'd2;
	localparam logic [3:0] S_MUL2   = 4'd3;
	localparam logic [3:0] S_DIV2   = 4'd4;
	localparam logic [3:0] S_RENORM = 4'd5;
	localparam logic [3:0] S_EMIT   = 4'd6;
	localparam logic [3:0] S_UNDER  = 4'd7;
	localparam logic [3:0] S_DRAIN  = 4'd8;

	logic [3:0]        state_q;
	logic [1:0]        cmd_q;
	logic [CNT_W-1:0]  base_q, freq_q, total_q, rem1_q;
	logic [DATA_W-1:0] low_q, range_q, thr_q, word_q;
	logic [PEND_W-1:0] pend_q, run_q;
	logic [7:0]        part_q;
	logic [2:0]        pcnt_q;
	logic              sat_q, head_q, head_bit_q, run_bit_q;
	logic [4:0]        wcnt_q;

	logic                 div_start, div_busy, div_done;
	logic [DIV_W-1:0]     div_dividend, div_quot;
	logic [CNT_W-1:0]     div_rem;
	logic [DATA_W:0]      range_p1;
	logic [CNT_W-1:0]     mul_op;
	logic [30:0]          prod, sum2, t2;
	logic [DATA_W-1:0]    lsum, word_n, range_n1, rm1, range_n2;
	logic [4:0]           n1, n2raw;
	logic [3:0]           n2;
	logic                 flush, clip, emit_en, emit_bit, push;
	logic [PEND_W:0]      psum;
	logic [7:0]           new_byte;
	logic                 drain_done;
	aenc_obuf_ctl_t       obuf_ctl;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// Shared multiplier: (range + 1) times base, then times freq
	assign range_p1 = {1'b0, range_q} + 17'd1;
	assign mul_op   = (state_q == S_MUL1) ? base_q : freq_q;
	assign prod     = {14'b0, range_p1} * {17'b0, mul_op};
	assign sum2     = prod + {17'b0, rem1_q};
	assign t2       = (sum2 < {17'b0, total_q}) ? 31'd0 : sum2 - {17'b0, total_q};

	assign div_start    = (state_q == S_MUL1) || (state_q == S_MUL2);
	assign div_dividend = (state_q == S_MUL1) ? prod[DIV_W-1:0] : t2[DIV_W-1:0];

	aenc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (total_q),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// Settled leading bits and the matching shift of low and range
	always_comb begin
		lsum     = low_q + range_q;
		n1       = lzc16(lsum ^ low_q);
		flush    = (n1 != 5'd0) && (pend_q != '0);
		word_n   = flush ? (low_q ^ TOP_BIT) : low_q;
		range_n1 = (range_q << n1) | ~(INITIAL_RANGE << n1);
	end

	// Underflow shift and pending count with clipping
	always_comb begin
		rm1      = range_q - 16'd1;
		n2raw    = lzc16(rm1);
		n2       = (n2raw == 5'd0) ? 4'd0 : 4'(n2raw - 5'd1);
		psum     = {1'b0, pend_q} + {3'b0, n2};
		clip     = (psum > (PEND_W + 1)'(PENDING_CAP));
		range_n2 = (range_q << n2) | ~(INITIAL_RANGE << n2);
	end

	// Bit emitter: head bit, then run bits, then word bits
	always_comb begin
		emit_en  = (state_q == S_EMIT) && (head_q || run_q != '0 || wcnt_q != 5'd0);
		emit_bit = head_q ? head_bit_q : ((run_q != '0) ? run_bit_q : word_q[DATA_W-1]);
		new_byte = emit_bit ? (part_q | (BYTE_MSB >> pcnt_q)) : part_q;
		push     = emit_en && (pcnt_q == 3'd7);
	end

	assign obuf_ctl.push      = push;
	assign obuf_ctl.push_byte = new_byte;
	assign obuf_ctl.drain     = (state_q == S_DRAIN);
	assign obuf_ctl.sat       = sat_q;

	aenc_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (obuf_ctl),
		.drain_done (drain_done),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	// Hold the fields of the accepted word
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q   <= s_tuser;
			base_q  <= s_tdata[13:0];
			freq_q  <= s_tdata[27:14];
			total_q <= s_tdata[41:28];
		end
		if (state_q == S_DIV1 && div_done) rem1_q <= div_rem;
		if (state_q == S_RENORM) word_q <= word_n;
		else if (emit_en && !head_q && run_q == '0) word_q <= {word_q[DATA_W-2:0], 1'b0};
	end

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= THRESH_RESET;
		else if (cfg_valid && cfg_ready) thr_q <= cfg_data;
	end

	// Sequencer and coder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			low_q      <= '0;
			range_q    <= INITIAL_RANGE;
			pend_q     <= '0;
			part_q     <= '0;
			pcnt_q     <= '0;
			sat_q      <= 1'b0;
			head_q     <= 1'b0;
			head_bit_q <= 1'b0;
			run_q      <= '0;
			run_bit_q  <= 1'b0;
			wcnt_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						sat_q <= 1'b0;
						case (s_tuser)
							CMD_ENCODE: begin
								state_q <= (s_tdata[41:28] != '0) ? S_MUL1 : S_DRAIN;
							end
							CMD_INIT: begin
								low_q   <= '0;
								range_q <= INITIAL_RANGE;
								state_q <= S_DRAIN;
							end
							CMD_FINISH: begin
								head_q     <= 1'b1;
								head_bit_q <= MARK_BIT;
								run_bit_q  <= ~MARK_BIT;
								run_q      <= PEND_W'(7);
								wcnt_q     <= 5'd0;
								state_q    <= S_EMIT;
							end
							default: state_q <= S_DRAIN;
						endcase
					end
				end
				S_MUL1: state_q <= S_DIV1;
				S_DIV1: begin
					if (div_done) begin
						low_q   <= low_q + div_quot[DATA_W-1:0];
						state_q <= S_MUL2;
					end
				end
				S_MUL2: state_q <= S_DIV2;
				S_DIV2: begin
					if (div_done) begin
						range_q <= div_quot[DATA_W-1:0];
						state_q <= S_RENORM;
					end
				end
				S_RENORM: begin
					wcnt_q  <= n1;
					low_q   <= word_n << n1;
					range_q <= range_n1;
					if (flush) begin
						head_q     <= 1'b1;
						head_bit_q <= low_q[DATA_W-1];
						run_bit_q  <= ~low_q[DATA_W-1];
						run_q      <= pend_q - PEND_W'(1);
						pend_q     <= '0;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_en) begin
						// advance the source of the bit
						if (head_q) head_q <= 1'b0;
						else if (run_q != '0) run_q <= run_q - PEND_W'(1);
						else wcnt_q <= wcnt_q - 5'd1;
						// pack the bit
						pcnt_q <= pcnt_q + 3'd1;
						part_q <= push ? 8'h00 : new_byte;
					end else begin
						state_q <= (cmd_q == CMD_ENCODE) ? S_UNDER : S_DRAIN;
					end
				end
				S_UNDER: begin
					if (range_q < thr_q) begin
						if (clip) begin
							pend_q <= PEND_W'(PENDING_CAP);
							sat_q  <= 1'b1;
						end else begin
							pend_q <= psum[PEND_W-1:0];
						end
						low_q   <= (low_q << n2) & LOW_MASK;
						range_q <= range_n2;
					end
					state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (drain_done) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_W'(PENDING_CAP))
		else $error("pending underflow count above its bound");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV1 || state_q == S_DIV2))
		else $error("divider finished outside a wait state");

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> (!div_busy && !head_q && run_q == '0 && wcnt_q == 5'd0))
		else $error("word accepted while work still in flight");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RENORM && flush) |=> (pend_q == '0 && head_q))
		else $error("pending bits not flushed");

endmodule
`default_nettype wire

FILE: sv/aenc_div.sv
// Iterative restoring divider, two quotient bits per cycle.
`default_nettype none
module aenc_div import aenc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DIV_W-1:0] quotient,
	output logic [CNT_W-1:0] remainder
);

	logic [DIV_W-1:0]     acc_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [CNT_W:0]   r1, r1d, r2, r2d;
	logic             ge1, ge2;
	logic [CNT_W-1:0] r1s, r2s;

	// Two dependent compare-subtract steps
	always_comb begin
		r1  = {rem_q, acc_q[DIV_W-1]};
		r1d = r1 - {1'b0, dvs_q};
		ge1 = (r1 >= {1'b0, dvs_q});
		r1s = ge1 ? r1d[CNT_W-1:0] : r1[CNT_W-1:0];
		r2  = {r1s, acc_q[DIV_W-2]};
		r2d = r2 - {1'b0, dvs_q};
		ge2 = (r2 >= {1'b0, dvs_q});
		r2s = ge2 ? r2d[CNT_W-1:0] : r2[CNT_W-1:0];
	end

	// Control: count the steps, pulse done after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift dividend out, quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[DIV_W-3:0], ge1, ge2};
			rem_q <= r2s;
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = acc_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

FILE: sv/aenc_obuf.sv
// Byte buffer of one item and the registered output stage.
`default_nettype none
module aenc_obuf import aenc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  aenc_obuf_ctl_t ctl,
	output logic           drain_done,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [15:0]    m_tdata,   // [7:0] code_byte, [8] underflow_saturated, rest zero
	output logic           m_tuser,   // [0] byte_valid
	output logic           m_tlast
);

	logic [7:0]           buf_q [BUF_DEPTH];
	logic [BUF_CNT_W-1:0] cnt_q;
	logic [BUF_CNT_W-1:0] rd_q;
	logic                 vld_q;
	logic [7:0]           byte_q;
	logic                 bv_q;
	logic                 last_q;
	logic                 sat_q;

	logic slot_free, load, empty_item, last_word;

	// Load the next word while draining, when the output register is free
	assign slot_free  = !vld_q || m_tready;
	assign load       = ctl.drain && slot_free;
	assign empty_item = (cnt_q == '0);
	assign last_word  = empty_item || ((rd_q + BUF_CNT_W'(1)) == cnt_q);
	assign drain_done = load && last_word;

	// Fill count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
			vld_q <= 1'b0;
		end else begin
			if (ctl.push && cnt_q != BUF_CNT_W'(BUF_DEPTH)) cnt_q <= cnt_q + BUF_CNT_W'(1);
			if (load) begin
				vld_q <= 1'b1;
				if (drain_done) begin
					rd_q  <= '0;
					cnt_q <= '0;
				end else begin
					rd_q <= rd_q + BUF_CNT_W'(1);
				end
			end else if (m_tready) begin
				vld_q <= 1'b0;
			end
		end
	end

	// Byte store
	always_ff @(posedge clk) begin
		if (ctl.push && cnt_q != BUF_CNT_W'(BUF_DEPTH)) buf_q[cnt_q[BUF_IDX_W-1:0]] <= ctl.push_byte;
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= empty_item ? 8'h00 : buf_q[rd_q[BUF_IDX_W-1:0]];
			bv_q   <= !empty_item;
			last_q <= last_word;
			sat_q  <= ctl.sat;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {7'b0, sat_q, byte_q};
	assign m_tuser  = bv_q;
	assign m_tlast  = last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= BUF_CNT_W'(BUF_DEPTH))
		else $error("byte buffer overfilled");

	a_drain_clears: assert property (@(posedge clk) disable iff (!arst_n)
		drain_done |=> (cnt_q == '0 && rd_q == '0 && vld_q))
		else $error("buffer not cleared after final word");

	a_no_push_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> !ctl.drain)
		else $error("byte pushed while draining");

endmodule
`default_nettype wire
